// ===== hdl/tld_pkg.sv =====
// Package for the terminal line discipline: payload structs, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tld_pkg;
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       request_last;
    } tld_in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic [1:0] status;
        logic       interrupt_raised;
        logic       line_end;
        logic       request_done;
    } tld_out_t;

    localparam logic [1:0] FUNC_MWRITE = 2'd0;
    localparam logic [1:0] FUNC_SWRITE = 2'd1;
    localparam logic [1:0] FUNC_MREAD  = 2'd2;
    localparam logic [1:0] FUNC_SREAD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BLOCK = 2'd1;
    localparam logic [1:0] ST_EOF   = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_INTR = 2'd1;
    localparam logic [1:0] REG_ERASE = 2'd2;
    localparam logic [1:0] REG_EOF  = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_READ_WAIT, S_ECHO, S_COMMIT_RD, S_COMMIT_WR,
        S_NL_PUSH, S_RESULT
    } tld_state_t;
endpackage
`default_nettype wire

// ===== hdl/tld_ram.sv =====
// Simple byte memory with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tld_ram #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/terminal_line_discipline_unit.sv =====
// Top level of the terminal line discipline: sequencer, ring pointers and registers.
// Depends on tld_pkg and tld_ram.
//
// Channel  Direction  Handshake                  Payload
// s_       in         s_valid / s_ready          tld_in_t
// m_       out        m_valid / m_ready          tld_out_t
// cfg_     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item at a time. A plain slave write passes from decode straight to the result state;
// a read passes through S_READ_WAIT and a master write through S_ECHO; erase echo adds
// further S_ECHO passes and a CR NL pair adds S_NL_PUSH. A newline or end-of-file commit
// alternates S_COMMIT_RD and S_COMMIT_WR per buffered byte, as each line-store read is registered.
// The result sits in an output register until taken; the next item is taken after.
// Reset is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module terminal_line_discipline_unit
    import tld_pkg::*;
#(
    parameter int RING_DEPTH = 1024,
    parameter int LINE_DEPTH = 256
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tld_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tld_out_t      m_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    localparam int RA = $clog2(RING_DEPTH);
    localparam int LA = $clog2(LINE_DEPTH);
    localparam int RF = $clog2(RING_DEPTH + 1);
    localparam int LF = $clog2(LINE_DEPTH + 1);
    localparam logic [RF-1:0] RING_FULL = RF'(RING_DEPTH);
    localparam logic [LF-1:0] LINE_FULL = LF'(LINE_DEPTH);
    localparam logic [RA-1:0] RING_LAST = RA'(RING_DEPTH - 1);

    tld_state_t state_reg, state_next;
    tld_in_t item_reg, item_next;
    tld_out_t res_reg, res_next;
    logic m_valid_reg, m_valid_next;
    logic [5:0] mode_reg;
    logic [7:0] intr_reg, erase_reg, eofc_reg;
    logic [RA-1:0] ih_reg, ih_next, it_reg, it_next, oh_reg, oh_next, ot_reg, ot_next;
    logic [RF-1:0] ifl_reg, ifl_next, ofl_reg, ofl_next;
    logic [LF-1:0] llen_reg, llen_next, cnt_reg, cnt_next;
    logic eofp_reg, eofp_next;
    logic [1:0] echo_reg, echo_next;
    logic [7:0] c_reg, c_next;

    logic in_we, out_we, line_we;
    logic [RA-1:0] in_ra, out_ra;
    logic [7:0] in_wd, out_wd, line_wd, in_rd, out_rd, line_rd;
    logic [LA-1:0] line_wa, line_ra;

    tld_ram #(.DEPTH(RING_DEPTH), .AW(RA)) u_in_ring (
        .aclk(aclk), .we(in_we), .waddr(it_reg), .wdata(in_wd), .raddr(in_ra), .rdata(in_rd));
    tld_ram #(.DEPTH(RING_DEPTH), .AW(RA)) u_out_ring (
        .aclk(aclk), .we(out_we), .waddr(ot_reg), .wdata(out_wd), .raddr(out_ra),
        .rdata(out_rd));
    tld_ram #(.DEPTH(LINE_DEPTH), .AW(LA)) u_line (
        .aclk(aclk), .we(line_we), .waddr(line_wa), .wdata(line_wd), .raddr(line_ra),
        .rdata(line_rd));

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = res_reg;
    assign in_ra = ih_reg;
    assign out_ra = oh_reg;
    assign line_ra = cnt_reg[LA-1:0];

    function automatic logic [RA-1:0] inc(input logic [RA-1:0] p);
        inc = (p == RING_LAST) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            mode_reg <= 6'd63;
            intr_reg <= 8'd3;
            erase_reg <= 8'h7f;
            eofc_reg <= 8'd4;
            ih_reg <= '0; it_reg <= '0; oh_reg <= '0; ot_reg <= '0;
            ifl_reg <= '0; ofl_reg <= '0; llen_reg <= '0; cnt_reg <= '0;
            eofp_reg <= 1'b0;
            echo_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            ih_reg <= ih_next; it_reg <= it_next; oh_reg <= oh_next; ot_reg <= ot_next;
            ifl_reg <= ifl_next; ofl_reg <= ofl_next; llen_reg <= llen_next;
            cnt_reg <= cnt_next; eofp_reg <= eofp_next; echo_reg <= echo_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[5:0];
                    REG_INTR: intr_reg <= cfg_data;
                    REG_ERASE: erase_reg <= cfg_data;
                    REG_EOF: eofc_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        item_reg <= item_next;
        res_reg <= res_next;
        c_reg <= c_next;
    end

    logic [RF-1:0] ispace, ospace;
    logic echo_on;

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        res_next = res_reg;
        m_valid_next = m_valid_reg;
        ih_next = ih_reg; it_next = it_reg; oh_next = oh_reg; ot_next = ot_reg;
        ifl_next = ifl_reg; ofl_next = ofl_reg; llen_next = llen_reg;
        cnt_next = cnt_reg; eofp_next = eofp_reg; echo_next = echo_reg;
        c_next = c_reg;
        in_we = 1'b0; out_we = 1'b0; line_we = 1'b0;
        in_wd = c_reg; out_wd = c_reg; line_wd = c_reg;
        line_wa = llen_reg[LA-1:0];
        ispace = RING_FULL - ifl_reg;
        ospace = RING_FULL - ofl_reg;
        echo_on = mode_reg[1];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    c_next = s_data.data_byte;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next = '0;
                res_next.request_done = item_reg.request_last;
                state_next = S_RESULT;
                case (item_reg.func)
                    FUNC_MWRITE: begin
                        if (mode_reg[3] && c_reg == CH_CR) begin
                            c_next = CH_NL;
                        end
                        state_next = S_ECHO;
                        echo_next = 2'd3;
                    end
                    FUNC_SWRITE: begin
                        if (mode_reg[4] && mode_reg[5] && c_reg == CH_NL) begin
                            if (ospace < RF'(2)) begin
                                res_next.status = ST_BLOCK;
                            end else begin
                                out_we = 1'b1; out_wd = CH_CR;
                                ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                                c_next = CH_NL;
                                state_next = S_NL_PUSH;
                            end
                        end else if (ofl_reg == RING_FULL) begin
                            res_next.status = ST_BLOCK;
                        end else begin
                            out_we = 1'b1;
                            ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                        end
                    end
                    FUNC_MREAD: begin
                        if (ofl_reg == '0) begin
                            res_next.status = ST_BLOCK;
                        end else begin
                            state_next = S_READ_WAIT;
                        end
                    end
                    default: begin
                        if (ifl_reg != '0) begin
                            state_next = S_READ_WAIT;
                        end else if (eofp_reg) begin
                            eofp_next = 1'b0;
                            res_next.status = ST_EOF;
                        end else begin
                            res_next.status = ST_BLOCK;
                        end
                    end
                endcase
            end
            S_READ_WAIT: begin
                res_next.read_valid = 1'b1;
                if (item_reg.func == FUNC_MREAD) begin
                    res_next.read_byte = out_rd;
                    oh_next = inc(oh_reg); ofl_next = ofl_reg - 1'b1;
                end else begin
                    res_next.read_byte = in_rd;
                    res_next.line_end = mode_reg[0] && in_rd == CH_NL;
                    ih_next = inc(ih_reg); ifl_next = ifl_reg - 1'b1;
                end
                state_next = S_RESULT;
            end
            S_ECHO: begin
                // Master write after CR mapping, echo_reg is 3 on first entry.
                state_next = S_RESULT;
                if (echo_reg == 2'd3) begin
                    if (mode_reg[2] && c_reg == intr_reg) begin
                        res_next.interrupt_raised = 1'b1;
                    end else if (!mode_reg[0]) begin
                        if (ifl_reg == RING_FULL) begin
                            res_next.status = ST_BLOCK;
                        end else begin
                            in_we = 1'b1;
                            it_next = inc(it_reg); ifl_next = ifl_reg + 1'b1;
                            if (echo_on && ofl_reg != RING_FULL) begin
                                out_we = 1'b1;
                                ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                            end
                        end
                    end else if (c_reg == erase_reg || c_reg == CH_BS) begin
                        if (llen_reg != '0) begin
                            llen_next = llen_reg - 1'b1;
                            if (echo_on) begin
                                echo_next = 2'd2;
                                state_next = S_ECHO;
                            end
                        end
                    end else if (c_reg == CH_NL) begin
                        if (ispace < RF'(llen_reg) + RF'(1)) begin
                            res_next.status = ST_BLOCK;
                        end else begin
                            cnt_next = '0;
                            state_next = S_COMMIT_RD;
                        end
                    end else if (c_reg == eofc_reg) begin
                        if (ispace < RF'(llen_reg)) begin
                            res_next.status = ST_BLOCK;
                        end else begin
                            if (llen_reg == '0) eofp_next = 1'b1;
                            cnt_next = '0;
                            state_next = S_COMMIT_RD;
                        end
                    end else if (llen_reg != LINE_FULL) begin
                        line_we = 1'b1;
                        llen_next = llen_reg + 1'b1;
                        if (echo_on && ofl_reg != RING_FULL) begin
                            out_we = 1'b1;
                            ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                        end
                    end
                end else begin
                    out_wd = (echo_reg == 2'd1) ? CH_SP : CH_BS;
                    if (ofl_reg != RING_FULL) begin
                        out_we = 1'b1;
                        ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                    end
                    echo_next = echo_reg - 1'b1;
                    state_next = (echo_reg == 2'd0) ? S_RESULT : S_ECHO;
                end
            end
            S_COMMIT_RD: begin
                if (cnt_reg == llen_reg) begin
                    llen_next = '0;
                    if (c_reg == CH_NL) begin
                        in_we = 1'b1; in_wd = CH_NL;
                        it_next = inc(it_reg); ifl_next = ifl_reg + 1'b1;
                        if (echo_on) begin
                            if (ofl_reg != RING_FULL) begin
                                out_we = 1'b1; out_wd = CH_CR;
                                ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                            end
                            state_next = S_NL_PUSH;
                        end else begin
                            state_next = S_RESULT;
                        end
                    end else begin
                        state_next = S_RESULT;
                    end
                end else begin
                    state_next = S_COMMIT_WR;
                end
            end
            S_COMMIT_WR: begin
                in_we = 1'b1; in_wd = line_rd;
                it_next = inc(it_reg); ifl_next = ifl_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                state_next = S_COMMIT_RD;
            end
            S_NL_PUSH: begin
                out_wd = CH_NL;
                if (ofl_reg != RING_FULL) begin
                    out_we = 1'b1;
                    ot_next = inc(ot_reg); ofl_next = ofl_reg + 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sim/tld_checker.sv =====
// Checker for the terminal line discipline: watches the input, result and register
// channels, predicts each result and compares it. Depends on tld_pkg.
`timescale 1ns / 1ps
module tld_checker
    import tld_pkg::*;
#(
    parameter int RING_DEPTH = 1024,
    parameter int LINE_DEPTH = 256
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire tld_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire tld_out_t m_data,
    input  wire logic     cfg_valid,
    input  wire logic     cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int            fail_count,
    output int            pending_count,
    output int            result_count
);
    logic [7:0] in_ring [RING_DEPTH];
    logic [7:0] out_ring [RING_DEPTH];
    logic [7:0] line_buf [LINE_DEPTH];
    int in_head, in_tail, in_fill;
    int out_head, out_tail, out_fill;
    int line_len;
    logic eof_flag;
    logic [5:0] mode;
    logic [7:0] intr_ch, erase_ch, eof_ch;
    tld_out_t expected_results[$];

    initial begin
        fail_count = 0;
        result_count = 0;
    end

    assign pending_count = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void put_in(logic [7:0] b);
        if (in_fill >= RING_DEPTH) return;
        in_ring[in_tail] = b;
        in_tail = (in_tail + 1) % RING_DEPTH;
        in_fill++;
    endfunction

    function automatic void put_out(logic [7:0] b);
        if (out_fill >= RING_DEPTH) return;
        out_ring[out_tail] = b;
        out_tail = (out_tail + 1) % RING_DEPTH;
        out_fill++;
    endfunction

    function automatic void flush_line();
        for (int k = 0; k < line_len; k++) put_in(line_buf[k]);
        line_len = 0;
    endfunction

    function automatic tld_out_t predict_result(tld_in_t item);
        tld_out_t r;
        logic [7:0] c;
        int space;
        r = '0;
        r.request_done = item.request_last;
        c = item.data_byte;
        case (item.func)
            FUNC_MWRITE: begin
                space = RING_DEPTH - in_fill;
                if (mode[3] && c == CH_CR) c = CH_NL;
                if (mode[2] && c == intr_ch) begin
                    r.interrupt_raised = 1'b1;
                end else if (!mode[0]) begin
                    if (space == 0) begin
                        r.status = ST_BLOCK;
                    end else begin
                        put_in(c);
                        if (mode[1]) put_out(c);
                    end
                end else if (c == erase_ch || c == CH_BS) begin
                    if (line_len > 0) begin
                        line_len--;
                        if (mode[1]) begin
                            put_out(CH_BS);
                            put_out(CH_SP);
                            put_out(CH_BS);
                        end
                    end
                end else if (c == CH_NL) begin
                    if (space < line_len + 1) begin
                        r.status = ST_BLOCK;
                    end else begin
                        flush_line();
                        put_in(CH_NL);
                        if (mode[1]) begin
                            put_out(CH_CR);
                            put_out(CH_NL);
                        end
                    end
                end else if (c == eof_ch) begin
                    if (space < line_len) begin
                        r.status = ST_BLOCK;
                    end else begin
                        if (line_len == 0) eof_flag = 1'b1;
                        flush_line();
                    end
                end else if (line_len < LINE_DEPTH) begin
                    line_buf[line_len] = c;
                    line_len++;
                    if (mode[1]) put_out(c);
                end
            end
            FUNC_SWRITE: begin
                space = RING_DEPTH - out_fill;
                if (mode[4] && mode[5] && c == CH_NL) begin
                    if (space < 2) begin
                        r.status = ST_BLOCK;
                    end else begin
                        put_out(CH_CR);
                        put_out(CH_NL);
                    end
                end else if (space == 0) begin
                    r.status = ST_BLOCK;
                end else begin
                    put_out(c);
                end
            end
            FUNC_MREAD: begin
                if (out_fill > 0) begin
                    r.read_byte = out_ring[out_head];
                    r.read_valid = 1'b1;
                    out_head = (out_head + 1) % RING_DEPTH;
                    out_fill--;
                end else begin
                    r.status = ST_BLOCK;
                end
            end
            default: begin
                if (in_fill > 0) begin
                    r.read_byte = in_ring[in_head];
                    r.read_valid = 1'b1;
                    in_head = (in_head + 1) % RING_DEPTH;
                    in_fill--;
                    r.line_end = mode[0] && r.read_byte == CH_NL;
                end else if (eof_flag) begin
                    eof_flag = 1'b0;
                    r.status = ST_EOF;
                end else begin
                    r.status = ST_BLOCK;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        tld_out_t want;
        if (!aresetn) begin
            in_head = 0; in_tail = 0; in_fill = 0;
            out_head = 0; out_tail = 0; out_fill = 0;
            line_len = 0;
            eof_flag = 1'b0;
            mode = 6'd63;
            intr_ch = 8'd3;
            erase_ch = 8'h7f;
            eof_ch = 8'd4;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:  mode = cfg_data[5:0];
                    REG_INTR:  intr_ch = cfg_data;
                    REG_ERASE: erase_ch = cfg_data;
                    default:   eof_ch = cfg_data;
                endcase
            end
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no expectation");
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte %h, want %h",
                            m_data.read_byte, want.read_byte));
                    if (m_data.read_valid !== want.read_valid)
                        report_mismatch($sformatf("read_valid %b, want %b",
                            m_data.read_valid, want.read_valid));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            m_data.status, want.status));
                    if (m_data.interrupt_raised !== want.interrupt_raised)
                        report_mismatch("interrupt_raised differs");
                    if (m_data.line_end !== want.line_end)
                        report_mismatch("line_end differs");
                    if (m_data.request_done !== want.request_done)
                        report_mismatch("request_done differs");
                end
            end
        end
    end
endmodule

// ===== sim/tb_terminal_line_discipline_unit.sv =====
// Testbench top for the terminal line discipline: drives byte traffic and register
// writes with random idling. Depends on tld_pkg, tld_checker and the block.
`timescale 1ns / 1ps
module tb_terminal_line_discipline_unit;
    import tld_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tld_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tld_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_MODE;
    logic [7:0] cfg_data = '0;
    int fail_count, pending_count, result_count;
    bit calm = 1'b0;
    int item_count = 0;

    always #6 aclk = ~aclk;

    terminal_line_discipline_unit dut (.*);

    tld_checker checker_i (.*);

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end

    task automatic send_item(logic [1:0] f, logic [7:0] b);
        while (!calm && $urandom_range(99) < 32) @(negedge aclk);
        s_data <= '{func: f, data_byte: b, request_last: 1'($urandom_range(1))};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        item_count++;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_byte(logic [7:0] special[6]);
        if ($urandom_range(99) < 35) return special[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    task automatic random_phase(int count, logic [7:0] special[6]);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40) send_item(FUNC_MWRITE, pick_byte(special));
            else if (r < 55) send_item(FUNC_SWRITE, pick_byte(special));
            else if (r < 75) send_item(FUNC_MREAD, 8'($urandom_range(255)));
            else send_item(FUNC_SREAD, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [7:0] sp[6];
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        sp = '{CH_CR, CH_NL, CH_BS, 8'd3, 8'h7f, 8'd4};
        calm = 1'b1;
        send_item(FUNC_MWRITE, 8'h61);
        send_item(FUNC_MWRITE, 8'h7f);
        send_item(FUNC_MWRITE, 8'h7f);
        send_item(FUNC_MWRITE, 8'h62);
        send_item(FUNC_MWRITE, CH_BS);
        send_item(FUNC_MWRITE, 8'hff);
        send_item(FUNC_MWRITE, CH_CR);
        send_item(FUNC_MWRITE, 8'd3);
        send_item(FUNC_MWRITE, 8'h00);
        send_item(FUNC_MWRITE, 8'd4);
        send_item(FUNC_MWRITE, 8'd4);
        send_item(FUNC_SWRITE, CH_NL);
        send_item(FUNC_SWRITE, 8'h00);
        for (int i = 0; i < 5; i++) send_item(FUNC_SREAD, 8'hff);
        for (int i = 0; i < 7; i++) send_item(FUNC_MREAD, 8'h00);
        calm = 1'b0;
        random_phase(90, sp);
        drain();
        // Raw mode with no echo and no special characters.
        write_reg(REG_MODE, 8'd0);
        write_reg(REG_INTR, 8'hff);
        write_reg(REG_ERASE, 8'h00);
        write_reg(REG_EOF, 8'h55);
        calm = 1'b1;
        for (int i = 0; i < 10; i++) send_item(FUNC_MWRITE, 8'($urandom_range(255)));
        for (int i = 0; i < 10; i++) send_item(FUNC_SWRITE, 8'($urandom_range(255)));
        for (int i = 0; i < 12; i++) send_item(FUNC_SREAD, 8'h00);
        for (int i = 0; i < 12; i++) send_item(FUNC_MREAD, 8'h00);
        calm = 1'b0;
        sp = '{CH_CR, CH_NL, CH_BS, 8'hff, 8'h00, 8'h55};
        random_phase(90, sp);
        drain();
        // Canonical with echo, long lines to overflow the line store.
        write_reg(REG_MODE, 8'd3);
        calm = 1'b1;
        for (int i = 0; i < 260; i++) send_item(FUNC_MWRITE, 8'h41);
        send_item(FUNC_MWRITE, CH_NL);
        calm = 1'b0;
        random_phase(90, sp);
        drain();
        write_reg(REG_MODE, 8'd63);
        write_reg(REG_INTR, 8'd3);
        write_reg(REG_ERASE, 8'h7f);
        write_reg(REG_EOF, 8'd4);
        sp = '{CH_CR, CH_NL, CH_BS, 8'd3, 8'h7f, 8'd4};
        random_phase(90, sp);
        drain();
        write_reg(REG_MODE, 8'($urandom_range(63)));
        calm = 1'b1;
        random_phase(90, sp);
        drain();
        $display("Covered %0d items and %0d results over five register settings,",
            item_count, result_count);
        $display("including raw, canonical, empty rings and a full line store.");
        if (fail_count == 0) begin
            $display("tb_terminal_line_discipline_unit passed");
        end else begin
            $display("tb_terminal_line_discipline_unit failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_terminal_line_discipline_unit failed");
        $finish;
    end
endmodule

// ===== terminal_line_discipline_unit.f =====
hdl/tld_pkg.sv
hdl/tld_ram.sv
hdl/terminal_line_discipline_unit.sv
sim/tld_checker.sv
sim/tb_terminal_line_discipline_unit.sv
